// ===== design/alkvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alkvs_pkg
// Shared types and constants of the append-only key/value log.
// ----------------------------------------------------------------------------
package alkvs_pkg;

  localparam int unsigned LOG_ENTRIES_DEF = 512;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 32;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic scan_en;
    logic record_hit;
    logic record_miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic lookup;
    logic match;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

// ===== design/alkvs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alkvs_ctrl
// Controller: sequences capture, append, backward scan and result handoff.
// ----------------------------------------------------------------------------
module alkvs_ctrl
  import alkvs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.lookup ? ST_SCAN : ST_APPEND;
        end
      end
      ST_APPEND: begin
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (status.match || status.exhausted) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_en     = 1'b1;
        cmd.record_hit  = status.match;
        cmd.record_miss = status.exhausted && !status.match;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/alkvs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alkvs_dp
// Datapath: entry memory, fill count, scan pointer and result registers.
// ----------------------------------------------------------------------------
module alkvs_dp
  import alkvs_pkg::*;
#(
  parameter int unsigned LOG_ENTRIES = LOG_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] write_value,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             hit,
  output logic [VAL_W-1:0] read_value,
  output logic             log_cleared,
  input  cmd_t             cmd,
  output status_t          status
);

  localparam int unsigned IW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(LOG_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_ENTRIES);

  logic [KEY_W+VAL_W-1:0] mem [LOG_ENTRIES];

  logic [CW-1:0]          count;
  logic [CW-1:0]          scan_left;
  logic [KEY_W-1:0]       key_reg;
  logic [VAL_W-1:0]       val_reg;
  logic                   rd_vld;
  logic [KEY_W+VAL_W-1:0] rd_word;
  logic                   res_hit;
  logic [VAL_W-1:0]       res_value;
  logic                   res_cleared;

  logic                   full;
  logic [IW-1:0]          wr_idx;
  logic                   rd_en;
  logic [CW-1:0]          scan_idx;
  logic                   match;

  assign full     = (count == FULL_COUNT);
  assign wr_idx   = full ? '0 : count[IW-1:0];
  assign rd_en    = cmd.scan_en && (scan_left != '0);
  assign scan_idx = scan_left - CW'(1);
  assign match    = rd_vld && (rd_word[KEY_W+VAL_W-1:VAL_W] == key_reg);

  assign status.lookup    = (func == FUNC_LOOKUP);
  assign status.match     = match;
  assign status.exhausted = (scan_left == '0) && !match;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_idx] <= {key_reg, val_reg};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[scan_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_left <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= full ? CW'(1) : count + CW'(1);
      end
      if (cmd.capture) begin
        scan_left <= count;
        rd_vld    <= 1'b0;
      end else begin
        if (rd_en) begin
          scan_left <= scan_idx;
        end
        rd_vld <= rd_en;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_reg <= key;
      val_reg <= write_value;
    end
    if (cmd.append) begin
      res_hit     <= 1'b0;
      res_value   <= '0;
      res_cleared <= full;
    end
    if (cmd.record_hit) begin
      res_hit     <= 1'b1;
      res_value   <= rd_word[VAL_W-1:0];
      res_cleared <= 1'b0;
    end
    if (cmd.record_miss) begin
      res_hit     <= 1'b0;
      res_value   <= '0;
      res_cleared <= 1'b0;
    end
    if (cmd.load_out) begin
      hit         <= res_hit;
      read_value  <= res_value;
      log_cleared <= res_cleared;
    end
  end

endmodule

// ===== design/append_log_key_value_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// append_log_key_value_store_unit
// Append-only key/value log with newest-first lookup.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid / in_ready  func, key, write_value
// out      out_valid/ out_ready hit, read_value, log_cleared
//
// Append: from acceptance to result the steps are capture, memory write, handoff.
// Lookup: one memory read per cycle from the newest entry back; the single
// read port sets this rate.
// Reset empties the log at once; entries are not cleared.
// A stalled result is held in the output register while the next
// transaction is accepted; that transaction then waits for the register.
// ----------------------------------------------------------------------------
module append_log_key_value_store_unit
  import alkvs_pkg::*;
#(
  parameter int unsigned LOG_ENTRIES = LOG_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] write_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             hit,
  output logic [VAL_W-1:0] read_value,
  output logic             log_cleared
);

  cmd_t    cmd;
  status_t status;

  alkvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  alkvs_dp #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .key         (key),
    .write_value (write_value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .hit         (hit),
    .read_value  (read_value),
    .log_cleared (log_cleared),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== sim/append_log_key_value_store_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// append_log_key_value_store_unit_tb
// Self-checking bench for the append-only key/value log. A short table of
// directed transactions covers the empty log, extreme keys and values,
// duplicate keys and misses. About a thousand random appends and lookups
// follow. They draw keys mostly from a small pool so that lookups hit, and
// they wrap the log past full so the erase path runs. A log shadow in the
// bench predicts results; typed directed rows use the table's result instead.
// Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module append_log_key_value_store_unit_tb;
  import alkvs_pkg::*;

  localparam int LOG_DEPTH    = LOG_ENTRIES_DEF;
  localparam int N_DIRECTED   = 19;
  localparam int N_RANDOM     = 1000;
  localparam int POOL_SIZE    = 12;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             cleared;
  } log_result_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] k_in;
    logic [VAL_W-1:0] v_in;
    logic             typed;
    log_result_t      res;
  } row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] write_value;
  logic             out_valid;
  logic             out_ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             log_cleared;

  logic             row_typed;
  log_result_t      row_result;

  logic [KEY_W-1:0] shadow_keys [LOG_DEPTH];
  logic [VAL_W-1:0] shadow_vals [LOG_DEPTH];
  int               shadow_fill;
  log_result_t      pending_results [$];
  int               fail_count;
  int               sender_idle_pct;
  int               receiver_stall_pct;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  row_t directed_rows [0:N_DIRECTED-1] = '{
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0}},
    '{FUNC_APPEND, 32'h1234_5678, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_APPEND, 32'h1234_5678, 32'h5A5A_5A5A, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'h1234_5678, 32'h0000_0000, 1'b1, '{1'b1, 32'h5A5A_5A5A, 1'b0}},
    '{FUNC_LOOKUP, 32'h1234_5679, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'h9234_5678, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_APPEND, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0001, 1'b0}},
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{FUNC_LOOKUP, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h5A5A_5A5A, 1'b0}},
    '{FUNC_APPEND, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0}},
    '{FUNC_APPEND, 32'h8000_0000, 32'h0F0F_F0F0, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}}
  };

  append_log_key_value_store_unit #(
    .LOG_ENTRIES(LOG_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .key        (key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .log_cleared(log_cleared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic log_result_t log_apply(input logic op, input logic [KEY_W-1:0] k,
                                            input logic [VAL_W-1:0] v);
    log_result_t r;
    int          idx;
    r = '0;
    if (op == FUNC_APPEND) begin
      if (shadow_fill >= LOG_DEPTH) begin
        shadow_fill = 0;
        r.cleared   = 1'b1;
      end
      shadow_keys[shadow_fill] = k;
      shadow_vals[shadow_fill] = v;
      shadow_fill++;
    end else begin
      for (idx = shadow_fill - 1; idx >= 0; idx--) begin
        if (shadow_keys[idx] == k) begin
          r.hit   = 1'b1;
          r.value = shadow_vals[idx];
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Transaction monitor: predict on input handshake, compare on output handshake.
  always @(posedge clk) begin
    log_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = log_apply(func, key, write_value);
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("%0t: unexpected result hit=%b value=%h cleared=%b",
                     $realtime, hit, read_value, log_cleared);
        end else begin
          want = pending_results.pop_front();
          if (hit !== want.hit || read_value !== want.value || log_cleared !== want.cleared)
          begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
              $display("%0t: mismatch exp hit=%b value=%h cleared=%b, got hit=%b value=%h cleared=%b",
                       $realtime, want.hit, want.value, want.cleared,
                       hit, read_value, log_cleared);
          end
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_item(input row_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func        <= r.op;
    key         <= r.k_in;
    write_value <= r.v_in;
    row_typed   <= r.typed;
    row_result  <= r.res;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    row_t rnd_row;
    int   n;
    rst                = 1'b1;
    in_valid           = 1'b0;
    func               = FUNC_APPEND;
    key                = '0;
    write_value        = '0;
    row_typed          = 1'b0;
    row_result         = '0;
    shadow_fill        = 0;
    fail_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    key_pool[0]        = 32'h0000_0000;
    key_pool[1]        = 32'hFFFF_FFFF;
    for (n = 2; n < POOL_SIZE; n++) key_pool[n] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) send_item(directed_rows[n]);

    for (n = 0; n < N_RANDOM; n++) begin
      case ((n / 125) % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 71;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 71;
        end
        default: begin
          sender_idle_pct    = 18;
          receiver_stall_pct = 18;
        end
      endcase
      rnd_row.op    = ($urandom_range(99) < 70) ? FUNC_APPEND : FUNC_LOOKUP;
      rnd_row.k_in  = pick_key();
      rnd_row.v_in  = $urandom;
      rnd_row.typed = 1'b0;
      rnd_row.res   = '0;
      send_item(rnd_row);
    end

    in_valid           <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LOG_DEPTH + 8) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
